// ===== sv/max_heap_insert_core_defines.svh =====
// Assertion macros for the max-heap insert core.
// Used by the top level only; no other dependencies.
`ifndef MAX_HEAP_INSERT_CORE_DEFINES_SVH
`define MAX_HEAP_INSERT_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define MHI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("max_heap_insert_core: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MHI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("max_heap_insert_core: assertion failed");
`else
`define MHI_ASSERT_IMPL(label, ante, cons)
`define MHI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/mhi_pkg.sv =====
// Shared types and constants for the max-heap insert core.
// No dependencies; used by mhi_sift and max_heap_insert_core.
package mhi_pkg;

    // Default heap depth and fixed field widths.
    localparam int MHI_CAPACITY = 64;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 7;

    // Sift-up sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP,
        ST_FIN
    } t_state;

    // One result word as produced by the sequencer.
    typedef struct packed {
        logic [VALUE_W-1:0] max_value;
        logic [COUNT_W-1:0] count;
        logic               dropped;
    } t_result;

endpackage

// ===== sv/mhi_ram.sv =====
// Single-port-write, single-port-read heap storage with registered read data.
// No package dependencies.
module mhi_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/mhi_sift.sv =====
// Sift-up sequencer: holds the fill count and root copy, walks the parent chain.
// Depends on mhi_pkg; drives the heap storage in mhi_ram.
module mhi_sift #(
    parameter int CAPACITY = mhi_pkg::MHI_CAPACITY,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mhi_pkg::VALUE_W-1:0] i_value,
    output logic                        o_busy,
    output logic                        o_done,
    output mhi_pkg::t_result            o_result,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [mhi_pkg::VALUE_W-1:0] o_wdata,
    output logic [AW-1:0]               o_raddr,
    input  logic [mhi_pkg::VALUE_W-1:0] i_rdata
);

    mhi_pkg::t_state r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [AW-1:0]                 r_slot, n_slot;
    logic [mhi_pkg::VALUE_W-1:0]   r_val, n_val;
    logic [mhi_pkg::VALUE_W-1:0]   r_root, n_root;

    logic          w_full;
    logic          w_parent_less;
    logic [AW-1:0] w_parent;
    logic [CW-1:0] w_count_inc;

    // Derived conditions.
    assign w_full        = (r_count == CW'(CAPACITY));
    assign w_parent      = (r_slot - AW'(1)) >> 1;
    assign w_parent_less = ($signed(i_rdata) < $signed(r_val));
    assign w_count_inc   = r_count + CW'(1);
    assign o_busy        = (r_state != mhi_pkg::ST_IDLE);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mhi_pkg::ST_IDLE: begin
                if (i_start && !w_full) begin
                    n_state = mhi_pkg::ST_CHECK;
                end
            end
            mhi_pkg::ST_CHECK: begin
                if (r_slot == '0) begin
                    n_state = mhi_pkg::ST_FIN;
                end else begin
                    n_state = mhi_pkg::ST_CMP;
                end
            end
            mhi_pkg::ST_CMP: begin
                if (w_parent_less) begin
                    n_state = mhi_pkg::ST_CHECK;
                end else begin
                    n_state = mhi_pkg::ST_FIN;
                end
            end
            mhi_pkg::ST_FIN: begin
                n_state = mhi_pkg::ST_IDLE;
            end
            default: begin
                n_state = mhi_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and datapath logic. The new value is held in r_val and smaller
    // parents are moved down one level each, so each level costs one read and
    // one write; the value lands where the chain stops.
    always_comb begin
        n_count  = r_count;
        n_slot   = r_slot;
        n_val    = r_val;
        n_root   = r_root;
        o_we     = 1'b0;
        o_waddr  = r_slot;
        o_wdata  = r_val;
        o_raddr  = w_parent;
        o_done   = 1'b0;
        o_result.max_value = r_root;
        o_result.count     = mhi_pkg::COUNT_W'(r_count);
        o_result.dropped   = 1'b0;
        case (r_state)
            mhi_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (w_full) begin
                        o_done           = 1'b1;
                        o_result.dropped = 1'b1;
                    end else begin
                        n_val  = i_value;
                        n_slot = r_count[AW-1:0];
                    end
                end
            end
            mhi_pkg::ST_CHECK: begin
                // At the root the value is placed; otherwise the parent read is in flight.
                if (r_slot == '0) begin
                    o_we   = 1'b1;
                    n_root = r_val;
                end
            end
            mhi_pkg::ST_CMP: begin
                o_we = 1'b1;
                if (w_parent_less) begin
                    o_wdata = i_rdata;
                    n_slot  = w_parent;
                end
            end
            mhi_pkg::ST_FIN: begin
                o_done         = 1'b1;
                n_count        = w_count_inc;
                o_result.count = mhi_pkg::COUNT_W'(w_count_inc);
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhi_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_val  <= n_val;
        r_root <= n_root;
    end

endmodule

// ===== sv/max_heap_insert_core.sv =====
// Top level of the max-heap insert core: storage, sift-up sequencer, result register.
// Depends on mhi_pkg, mhi_ram, mhi_sift and max_heap_insert_core_defines.svh.
//
// Usage: present a signed 32-bit word on i_value and raise start; the word is
// taken at a rising edge where start is high and busy is low. Each word gives
// exactly one result: o_valid is high for one cycle with o_max_value (the heap
// root), o_count (elements held) and o_dropped (heap was full, word discarded).
// The receiver cannot stall the block; it must take the result in that cycle.
// Sequence: busy stays high through a CHECK and a CMP state for each level the
// word moves up, then a last CHECK when it reaches the root, or a CHECK and a
// CMP when it stops below it, then FIN; the result shows in the first cycle
// that busy is low again. With the default depth of 64 the chain is at most six
// levels. Each level costs one read and one write of the single heap memory. A
// dropped word holds busy low and gives its result in the next cycle. A new word
// may be started in the same cycle that the previous result shows.
// Reset (synchronous, active low) empties the heap; the memory is not cleared,
// since only slots below the fill count are ever read.
`include "max_heap_insert_core_defines.svh"
module max_heap_insert_core #(
    parameter int CAPACITY = mhi_pkg::MHI_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic signed [mhi_pkg::VALUE_W-1:0] i_value,
    output logic                               busy,
    output logic                               o_valid,
    output logic signed [mhi_pkg::VALUE_W-1:0] o_max_value,
    output logic        [mhi_pkg::COUNT_W-1:0] o_count,
    output logic                               o_dropped
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                        w_done;
    mhi_pkg::t_result            w_result;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [mhi_pkg::VALUE_W-1:0] w_wdata;
    logic [AW-1:0]               w_raddr;
    logic [mhi_pkg::VALUE_W-1:0] w_rdata;
    logic                        r_valid;
    mhi_pkg::t_result            r_result;

    // Heap storage.
    mhi_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (mhi_pkg::VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sift-up sequencer.
    mhi_sift #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_sift (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_value  (i_value),
        .o_busy   (busy),
        .o_done   (w_done),
        .o_result (w_result),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata)
    );

    // Result register: strobe is cleared by reset, the word is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_result <= w_result;
        end
    end

    assign o_valid     = r_valid;
    assign o_max_value = r_result.max_value;
    assign o_count     = r_result.count;
    assign o_dropped   = r_result.dropped;

    // An accepted word either starts a sift or yields a dropped result next cycle.
    `MHI_ASSERT_NEXT(a_accept_progress, start && !busy, busy || (o_valid && o_dropped))
    // A result only shows once the sequencer has gone back to idle.
    `MHI_ASSERT_IMPL(a_valid_idle, o_valid, !busy)
    // A stored word always leaves at least one element in the heap.
    `MHI_ASSERT_IMPL(a_count_nonzero, o_valid && !o_dropped, o_count != '0)
    // A drop only happens with the heap at full depth.
    `MHI_ASSERT_IMPL(a_drop_full, o_valid && o_dropped,
        o_count == mhi_pkg::COUNT_W'(CAPACITY))

endmodule

// ===== verif/tb_max_heap_insert_core.sv =====
// Testbench for max_heap_insert_core: feeds signed words and checks every result word.
// Depends on mhi_pkg and max_heap_insert_core; a class tracks the expected heap contents.
`timescale 1ns / 1ps

module tb_max_heap_insert_core;

    // Tracks the heap as the block should hold it and the result words still owed.
    class heap_tracker;
        logic signed [mhi_pkg::VALUE_W-1:0] slots [mhi_pkg::MHI_CAPACITY];
        int unsigned                        fill;
        mhi_pkg::t_result                   owed [$];
        int unsigned                        mismatches;

        // Insert one accepted word with sift-up and queue the result it must produce.
        function void record_insert(logic signed [mhi_pkg::VALUE_W-1:0] word);
            mhi_pkg::t_result                   rep;
            int unsigned                        pos;
            int unsigned                        up;
            logic signed [mhi_pkg::VALUE_W-1:0] tmp;
            bit                                 climbing;
            rep.dropped = 1'b0;
            if (fill >= mhi_pkg::MHI_CAPACITY) begin
                rep.dropped = 1'b1;
            end else begin
                slots[fill] = word;
                pos = fill;
                climbing = 1'b1;
                // Equal values stay put; only a strictly smaller parent is swapped.
                while (climbing && pos > 0) begin
                    up = (pos - 1) / 2;
                    if (slots[up] < slots[pos]) begin
                        tmp = slots[up];
                        slots[up] = slots[pos];
                        slots[pos] = tmp;
                        pos = up;
                    end else begin
                        climbing = 1'b0;
                    end
                end
                fill++;
            end
            rep.max_value = slots[0];
            rep.count = fill[mhi_pkg::COUNT_W-1:0];
            owed.push_back(rep);
        endfunction

        // Compare one result word with the oldest one owed.
        function void check_report(logic [mhi_pkg::VALUE_W-1:0] max_value,
                                   logic [mhi_pkg::COUNT_W-1:0] count,
                                   logic dropped);
            mhi_pkg::t_result rep;
            if (owed.size() == 0) begin
                $error("result word with no insert pending: max_value %0d count %0d dropped %0b",
                       $signed(max_value), count, dropped);
                mismatches++;
                return;
            end
            rep = owed.pop_front();
            if (max_value !== rep.max_value) begin
                $error("max_value: expected %0d, got %0d",
                       $signed(rep.max_value), $signed(max_value));
                mismatches++;
            end
            if (count !== rep.count) begin
                $error("count: expected %0d, got %0d", rep.count, count);
                mismatches++;
            end
            if (dropped !== rep.dropped) begin
                $error("dropped: expected %0b, got %0b", rep.dropped, dropped);
                mismatches++;
            end
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic signed [mhi_pkg::VALUE_W-1:0] i_value = '0;
    logic                               busy;
    logic                               o_valid;
    logic signed [mhi_pkg::VALUE_W-1:0] o_max_value;
    logic        [mhi_pkg::COUNT_W-1:0] o_count;
    logic                               o_dropped;

    heap_tracker tracker = new();

    max_heap_insert_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_value     (i_value),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_max_value (o_max_value),
        .o_count     (o_count),
        .o_dropped   (o_dropped)
    );

    always #5 i_clk = ~i_clk;

    // Every result word is checked in the cycle it shows.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            tracker.check_report(o_max_value, o_count, o_dropped);
        end
    end

    // Present one word and hold it until the block takes it.
    task automatic insert_word(input logic signed [mhi_pkg::VALUE_W-1:0] word);
        start <= 1'b1;
        i_value <= word;
        do @(posedge i_clk); while (busy);
        tracker.record_insert(word);
    endtask

    // Leave start low for a while, with junk on the value port.
    task automatic hold_off(input int unsigned cycles);
        start <= 1'b0;
        i_value <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stimulus: directed corner words, then a random mix that fills the heap and overflows it.
    initial begin
        logic signed [mhi_pkg::VALUE_W-1:0] corner_words [$];
        logic signed [mhi_pkg::VALUE_W-1:0] ladder;
        logic signed [mhi_pkg::VALUE_W-1:0] word;
        int unsigned                        n;

        corner_words = '{32'sh8000_0000, 32'sh8000_0000, -2, -1, -1, 0, 1, 2, 100, 1000,
                         1001, 32'sh4000_0000, 32'sh4000_0000, 32'sh5000_0000, -5, 3};
        ladder = 32'sh5000_0001;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes, ties and words that climb to the root.
        foreach (corner_words[k]) begin
            insert_word(corner_words[k]);
            if ($urandom_range(0, 99) < 6) hold_off($urandom_range(1, 16));
        end

        // Random part; the largest value is held back for the last free slot so that it
        // climbs the full height of the tree, and everything after that is dropped.
        for (n = 0; n < 434; n++) begin
            if (tracker.fill == mhi_pkg::MHI_CAPACITY - 1) begin
                word = 32'sh7FFF_FFFF;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: word = $urandom;
                    4, 5:       word = $signed($urandom_range(0, 8)) - 4;
                    6: begin
                        case ($urandom_range(0, 3))
                            0:       word = 32'sh8000_0000;
                            1:       word = 32'sh7FFF_FFFE;
                            2:       word = 0;
                            default: word = -1;
                        endcase
                    end
                    default: begin
                        ladder = ladder + $urandom_range(1, 5000);
                        word = ladder;
                    end
                endcase
                // Once the heap is full any word may come, the largest one too.
                if (tracker.fill >= mhi_pkg::MHI_CAPACITY && $urandom_range(0, 9) == 0)
                    word = 32'sh7FFF_FFFF;
            end
            insert_word(word);
            // A long stretch in the middle runs with no gaps at all.
            if ((n < 150 || n >= 300) && $urandom_range(0, 99) < 6)
                hold_off($urandom_range(1, 16));
        end
        hold_off(1);

        // Drain the owed results, then give the block time to show anything extra.
        while (tracker.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.owed.size() == 0) begin
            $display("tb_max_heap_insert_core passed");
        end else begin
            if (tracker.owed.size() != 0)
                $error("%0d result words never arrived", tracker.owed.size());
            $display("tb_max_heap_insert_core failed");
        end
        $finish;
    end

    // Watchdog: the whole run takes well under a tenth of this.
    initial begin
        #2_000_000;
        $display("tb_max_heap_insert_core failed");
        $finish;
    end

endmodule
